@@ hdl/ar_pkg.sv @@
package ar_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 4;
  localparam int MAX_FRAC       = 8;

  localparam int OP_W     = 2;
  localparam int CENTER_W = 14;
  localparam int RADIUS_W = 11;
  localparam int PIX_W    = 8;
  localparam int RDADDR_W = 8;
  localparam int DIM_W    = 9;
  localparam int COORD_W  = 12;
  localparam int SPAN_W   = 16;
  localparam int POS_W    = COORD_W + MAX_FRAC + 1;
  localparam int DELTA_W  = 13;
  localparam int SQ_W     = 2 * DELTA_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int RAD2_W   = 2 * RADIUS_W;

  localparam int QUEUE_DEPTH = 2;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_FRAME_WIDTH      = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_BACKGROUND_LEVEL = 2'd2;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [PIX_W-1:0] RST_BACKGROUND   = 8'd0;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // for reads, c_lo/r_lo carry the pixel address and paint the in-frame flag
  typedef struct packed {
    op_e                        op;
    logic                       paint;
    logic [COORD_W-1:0]         c_lo;
    logic [COORD_W-1:0]         c_hi;
    logic [COORD_W-1:0]         r_lo;
    logic [COORD_W-1:0]         r_hi;
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [RAD2_W-1:0]          ro2;
    logic [RAD2_W-1:0]          ri2;
    logic [PIX_W-1:0]           ink;
  } job_t;

endpackage

@@ hdl/ar_ram.sv @@
module ar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ar_front.sv @@
module ar_front import ar_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic [OP_W-1:0]            opcode_i,
  input  logic signed [CENTER_W-1:0] center_x_q4_i,
  input  logic signed [CENTER_W-1:0] center_y_q4_i,
  input  logic [RADIUS_W-1:0]        outer_radius_q4_i,
  input  logic [RADIUS_W-1:0]        inner_radius_q4_i,
  input  logic [PIX_W-1:0]           ink_i,
  input  logic [RDADDR_W-1:0]        read_col_i,
  input  logic [RDADDR_W-1:0]        read_row_i,
  input  logic [DIM_W-1:0]           frame_width_i,
  input  logic [DIM_W-1:0]           frame_height_i,
  output job_t                       job_o
);

  localparam logic [COORD_W:0] MAXW = (COORD_W + 1)'(MAX_WIDTH);
  localparam logic [COORD_W:0] MAXH = (COORD_W + 1)'(MAX_HEIGHT);

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } span_t;

  function automatic logic [COORD_W:0] clamp_dim(logic [DIM_W-1:0] v, logic [COORD_W:0] maxv);
    logic [COORD_W:0] ext;
    ext = (COORD_W + 1)'(v);
    if (v == '0) begin
      return (COORD_W + 1)'(1);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

  // clipped scan range along one axis: truncated start, floor of far edge
  function automatic span_t axis_span(logic signed [CENTER_W-1:0] ctr,
                                      logic [RADIUS_W-1:0] rad, logic [COORD_W:0] dim);
    logic signed [SPAN_W-1:0] lo_s;
    logic signed [SPAN_W-1:0] hi_s;
    logic signed [SPAN_W-1:0] lo_c;
    logic signed [SPAN_W-1:0] hi_c;
    logic signed [SPAN_W-1:0] last;
    span_t                    s;
    lo_s = SPAN_W'(ctr) - SPAN_W'(rad);
    hi_s = SPAN_W'(ctr) + SPAN_W'(rad);
    lo_c = (lo_s < 0) ? '0 : (lo_s >>> FRAC_BITS);
    hi_c = hi_s >>> FRAC_BITS;
    last = SPAN_W'(dim) - SPAN_W'(1);
    s.ok = (hi_c >= lo_c) && (lo_c <= last);
    s.lo = lo_c[COORD_W-1:0];
    s.hi = (hi_c < last) ? hi_c[COORD_W-1:0] : last[COORD_W-1:0];
    return s;
  endfunction

  logic [COORD_W:0] fw;
  logic [COORD_W:0] fh;
  span_t            xs;
  span_t            ys;
  logic             rd_ok;

  assign fw    = clamp_dim(frame_width_i, MAXW);
  assign fh    = clamp_dim(frame_height_i, MAXH);
  assign xs    = axis_span(center_x_q4_i, outer_radius_q4_i, fw);
  assign ys    = axis_span(center_y_q4_i, outer_radius_q4_i, fh);
  assign rd_ok = ((COORD_W + 1)'(read_col_i) < fw) && ((COORD_W + 1)'(read_row_i) < fh);

  always_comb begin
    job_o       = '0;
    job_o.op    = op_e'(opcode_i);
    job_o.cx    = center_x_q4_i;
    job_o.cy    = center_y_q4_i;
    job_o.ink   = ink_i;
    job_o.ro2   = RAD2_W'(outer_radius_q4_i) * RAD2_W'(outer_radius_q4_i);
    job_o.ri2   = RAD2_W'(inner_radius_q4_i) * RAD2_W'(inner_radius_q4_i);
    case (op_e'(opcode_i))
      OP_DRAW: begin
        job_o.paint = xs.ok && ys.ok && (inner_radius_q4_i < outer_radius_q4_i);
        job_o.c_lo  = xs.lo;
        job_o.c_hi  = xs.hi;
        job_o.r_lo  = ys.lo;
        job_o.r_hi  = ys.hi;
      end
      OP_READ: begin
        job_o.paint = rd_ok;
        job_o.c_lo  = COORD_W'(read_col_i);
        job_o.r_lo  = COORD_W'(read_row_i);
      end
      default: begin
        job_o.paint = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/ar_queue.sv @@
module ar_queue import ar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ hdl/ar_back.sv @@
module ar_back import ar_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  job_t                  head_i,
  output logic                  pop_o,
  input  logic [PIX_W-1:0]      bg_level_i,
  output logic                  init_o,
  output logic                  ram_we_o,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] ram_waddr_o,
  output logic [PIX_W-1:0]      ram_wdata_o,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] ram_raddr_o,
  input  logic [PIX_W-1:0]      ram_rdata_i,
  output logic                  done_o,
  output logic [PIX_W-1:0]      pixel_value_o,
  output logic [OP_W-1:0]       done_opcode_o
);

  localparam int COL_AW = $clog2(MAX_WIDTH);
  localparam int ROW_AW = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_AW + ROW_AW;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [COORD_W-1:0]       col_q, col_d;
  logic [COORD_W-1:0]       row_q, row_d;
  logic [ADDR_W-1:0]        sweep_q, sweep_d;
  job_t                     job_q, job_d;
  logic                     done_q, done_d;
  logic [PIX_W-1:0]         pix_q, pix_d;
  op_e                      dop_q, dop_d;
  logic                     issue;

  logic                     v1_q, v2_q;
  logic signed [DELTA_W-1:0] dx_q, dy_q;
  logic [ADDR_W-1:0]        addr1_q, addr2_q;
  logic signed [SQ_W-1:0]   sqx_q, sqy_q;
  logic signed [POS_W-1:0]  xpos, ypos, dx_w, dy_w;
  logic signed [SQ_W-1:0]   sqx_w, sqy_w;
  logic [DIST_W-1:0]        d2;
  logic                     hit;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    sweep_d = sweep_q;
    job_d   = job_q;
    pix_d   = pix_q;
    dop_d   = dop_q;
    done_d  = 1'b0;
    pop_o   = 1'b0;
    issue   = 1'b0;
    case (state_q)
      ST_INIT: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o  = 1'b1;
          job_d  = head_i;
          done_d = 1'b1;
          pix_d  = '0;
          dop_d  = head_i.op;
          case (head_i.op)
            OP_DRAW: begin
              if (head_i.paint) begin
                done_d  = 1'b0;
                state_d = ST_SCAN;
                col_d   = head_i.c_lo;
                row_d   = head_i.r_lo;
              end
            end
            OP_READ: begin
              if (head_i.paint) begin
                done_d  = 1'b0;
                state_d = ST_READ;
              end
            end
            OP_CLEAR: begin
              done_d  = 1'b0;
              state_d = ST_SWEEP;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          pix_d   = '0;
          dop_d   = OP_CLEAR;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (row_q == job_q.r_hi) begin
          row_d = job_q.r_lo;
          if (col_q == job_q.c_hi) begin
            state_d = ST_DRAIN;
          end else begin
            col_d = col_q + 1'b1;
          end
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!v1_q) begin
          state_d = ST_IDLE;
          col_d   = '0;
          row_d   = '0;
          done_d  = 1'b1;
          pix_d   = '0;
          dop_d   = OP_DRAW;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        pix_d   = ram_rdata_i;
        dop_d   = OP_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // distance test pipeline: offsets, squares, sum and compare
  assign xpos  = POS_W'(col_q) << FRAC_BITS;
  assign ypos  = POS_W'(row_q) << FRAC_BITS;
  assign dx_w  = xpos - POS_W'(job_q.cx);
  assign dy_w  = ypos - POS_W'(job_q.cy);
  assign sqx_w = SQ_W'(dx_q) * SQ_W'(dx_q);
  assign sqy_w = SQ_W'(dy_q) * SQ_W'(dy_q);
  assign d2    = DIST_W'(unsigned'(sqx_q)) + DIST_W'(unsigned'(sqy_q));
  assign hit   = v2_q && (d2 < DIST_W'(job_q.ro2)) && (d2 > DIST_W'(job_q.ri2));

  always_comb begin
    ram_we_o    = hit;
    ram_waddr_o = addr2_q;
    ram_wdata_o = job_q.ink;
    if (state_q == ST_INIT) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = sweep_q;
      ram_wdata_o = RST_BACKGROUND;
    end else if (state_q == ST_SWEEP) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = sweep_q;
      ram_wdata_o = bg_level_i;
    end
  end

  assign ram_raddr_o = {head_i.r_lo[ROW_AW-1:0], head_i.c_lo[COL_AW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      col_q   <= '0;
      row_q   <= '0;
      sweep_q <= '0;
      done_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      sweep_q <= sweep_d;
      done_q  <= done_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    pix_q   <= pix_d;
    dop_q   <= dop_d;
    dx_q    <= dx_w[DELTA_W-1:0];
    dy_q    <= dy_w[DELTA_W-1:0];
    addr1_q <= {row_q[ROW_AW-1:0], col_q[COL_AW-1:0]};
    sqx_q   <= sqx_w;
    sqy_q   <= sqy_w;
    addr2_q <= addr1_q;
  end

  assign init_o        = (state_q == ST_INIT);
  assign done_o        = done_q;
  assign pixel_value_o = pix_q;
  assign done_opcode_o = dop_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!v1_q && !v2_q))
    else $error("distance pipeline not drained while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((col_q <= job_q.c_hi) && (row_q <= job_q.r_hi)))
    else $error("scan position outside bounding box");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !done_q)
    else $error("result during post-reset clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> ((state_q == ST_SCAN) || (state_q == ST_DRAIN)))
    else $error("ring pixel write outside a draw");
`endif

endmodule

@@ hdl/annulus_rasterizer.sv @@
// Ring rasterizer over an 8-bit grey frame store of 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT))
// pixels. An item is taken when start is high and busy is low; every item gives exactly
// one result, shown on done_o for a single cycle together with pixel_value_o and
// done_opcode_o, and the receiver cannot stall it. Items pass through a two-entry queue,
// so busy rises only while the queue is full or while the store is being cleared after
// reset. That clearing pass writes one pixel per cycle over the full store depth; a clear
// item sweeps the store in the same way with the background level, as the store has a
// single write port. A draw tests one pixel per cycle over the clipped bounding box of
// the ring and then waits for the distance pipeline to drain; an empty box is finished
// without a scan. A read goes through the registered read port. The user must write
// frame size and background level over the APB port only while no item is outstanding;
// the block itself does not enforce this.
module annulus_rasterizer import ar_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            opcode_i,
  input  logic signed [CENTER_W-1:0] center_x_q4_i,
  input  logic signed [CENTER_W-1:0] center_y_q4_i,
  input  logic [RADIUS_W-1:0]        outer_radius_q4_i,
  input  logic [RADIUS_W-1:0]        inner_radius_q4_i,
  input  logic [PIX_W-1:0]           ink_i,
  input  logic [RDADDR_W-1:0]        read_col_i,
  input  logic [RDADDR_W-1:0]        read_row_i,
  output logic                       done_o,
  output logic [PIX_W-1:0]           pixel_value_o,
  output logic [OP_W-1:0]            done_opcode_o
);

  localparam int ADDR_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
  localparam int DEPTH  = 2 ** ADDR_W;

  logic [DIM_W-1:0]  frame_width_q;
  logic [DIM_W-1:0]  frame_height_q;
  logic [PIX_W-1:0]  background_level_q;
  logic              cfg_wr;

  job_t              job_in;
  job_t              head;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  logic              init_busy;
  logic              accept;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PIX_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q      <= RST_FRAME_WIDTH;
      frame_height_q     <= RST_FRAME_HEIGHT;
      background_level_q <= RST_BACKGROUND;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_FRAME_WIDTH:      frame_width_q      <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:     frame_height_q     <= pwdata[DIM_W-1:0];
        REG_BACKGROUND_LEVEL: background_level_q <= pwdata[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_FRAME_WIDTH:      prdata = PDATA_W'(frame_width_q);
      REG_FRAME_HEIGHT:     prdata = PDATA_W'(frame_height_q);
      REG_BACKGROUND_LEVEL: prdata = PDATA_W'(background_level_q);
      default:              prdata = '0;
    endcase
  end

  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  ar_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .opcode_i         (opcode_i),
    .center_x_q4_i    (center_x_q4_i),
    .center_y_q4_i    (center_y_q4_i),
    .outer_radius_q4_i(outer_radius_q4_i),
    .inner_radius_q4_i(inner_radius_q4_i),
    .ink_i            (ink_i),
    .read_col_i       (read_col_i),
    .read_row_i       (read_row_i),
    .frame_width_i    (frame_width_q),
    .frame_height_i   (frame_height_q),
    .job_o            (job_in)
  );

  ar_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .job_i  (job_in),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head)
  );

  ar_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .bg_level_i   (background_level_q),
    .init_o       (init_busy),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .done_o       (done_o),
    .pixel_value_o(pixel_value_o),
    .done_opcode_o(done_opcode_o)
  );

  ar_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
